### hw/rtl/dsf_pkg.sv
// dsf_pkg: shared constants, types and the digit-to-segment map for the
// decimal seven-segment frame generator; no dependencies
`default_nettype none

package dsf_pkg;

   // controller commands
   localparam logic [7:0] CMD_DATA_MODE = 8'h40;
   localparam logic [7:0] CMD_ADDRESS   = 8'hC0;
   localparam logic [7:0] CMD_DISPLAY   = 8'h80;

   localparam int         CTRL_W        = 4;
   localparam logic [3:0] CONTROL_RESET = 4'(4'h7 | 4'h8);

   localparam int          VALUE_W   = 16;
   localparam int          SAT_W     = 14;
   localparam logic [13:0] MAX_SHOWN = 14'd9999;

   localparam int NUM_DIGITS = 4;
   localparam int POS_W      = 3;

   // byte positions within one run
   localparam logic [2:0] POS_DATA_MODE = 3'd0;
   localparam logic [2:0] POS_ADDRESS   = 3'd1;
   localparam logic [2:0] POS_THOUSANDS = 3'd2;
   localparam logic [2:0] POS_HUNDREDS  = 3'd3;
   localparam logic [2:0] POS_TENS      = 3'd4;
   localparam logic [2:0] POS_UNITS     = 3'd5;
   localparam logic [2:0] POS_DISPLAY   = 3'd6;

   // segment bytes for one value, thousands at index 0
   typedef struct packed {
      logic [NUM_DIGITS-1:0][7:0] seg;
      logic                       overflowed;
   } frame_type;

   // bit 0 = segment a .. bit 6 = segment g
   function automatic logic [7:0] seg_of(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0:    pat = 8'b0011_1111;
         4'd1:    pat = 8'b0000_0110;
         4'd2:    pat = 8'b0101_1011;
         4'd3:    pat = 8'b0100_1111;
         4'd4:    pat = 8'b0110_0110;
         4'd5:    pat = 8'b0110_1101;
         4'd6:    pat = 8'b0111_1101;
         4'd7:    pat = 8'b0000_0111;
         4'd8:    pat = 8'b0111_1111;
         4'd9:    pat = 8'b0110_1111;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/dsf_conv.sv
// dsf_conv: clamps a 16-bit value to 9999, splits it into decimal digits and
// maps them to segment bytes; uses dsf_pkg
`default_nettype none

module dsf_conv (
   input  wire logic [dsf_pkg::VALUE_W-1:0] value,
   output dsf_pkg::frame_type               frame
);

   logic [dsf_pkg::SAT_W-1:0] sat;
   logic                      ovf;
   logic [3:0]                d_thou, d_hund, d_tens, d_unit;
   logic [13:0]               sub_thou;
   logic [9:0]                rem_thou, sub_hund;
   logic [6:0]                rem_hund, sub_tens;

   always_comb begin
      ovf = (value > dsf_pkg::VALUE_W'(dsf_pkg::MAX_SHOWN));
      sat = ovf ? dsf_pkg::MAX_SHOWN : value[dsf_pkg::SAT_W-1:0];

      // each digit picks the largest multiple that fits, compares in parallel
      d_thou   = 4'd0;
      sub_thou = 14'd0;
      for (int k = 1; k < 10; k++) begin
         if (sat >= 14'(k * 1000)) begin
            d_thou   = 4'(k);
            sub_thou = 14'(k * 1000);
         end
      end
      rem_thou = 10'(sat - sub_thou);

      d_hund   = 4'd0;
      sub_hund = 10'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem_thou >= 10'(k * 100)) begin
            d_hund   = 4'(k);
            sub_hund = 10'(k * 100);
         end
      end
      rem_hund = 7'(rem_thou - sub_hund);

      d_tens   = 4'd0;
      sub_tens = 7'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem_hund >= 7'(k * 10)) begin
            d_tens   = 4'(k);
            sub_tens = 7'(k * 10);
         end
      end
      d_unit = 4'(rem_hund - sub_tens);

      frame.seg[0]      = dsf_pkg::seg_of(d_thou);
      frame.seg[1]      = dsf_pkg::seg_of(d_hund);
      frame.seg[2]      = dsf_pkg::seg_of(d_tens);
      frame.seg[3]      = dsf_pkg::seg_of(d_unit);
      frame.overflowed  = ovf;
   end

endmodule

`default_nettype wire

### hw/rtl/dsf_emit.sv
// dsf_emit: holds one converted frame and sends its seven bytes, one per
// cycle, with transfer flags; uses dsf_pkg
`default_nettype none

module dsf_emit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         load,
   input  wire dsf_pkg::frame_type           frame,
   input  wire logic [dsf_pkg::CTRL_W-1:0]   display_control,
   output logic                              ready,
   output logic                              rsp_valid,
   output logic [7:0]                        rsp_frame_byte,
   output logic                              rsp_begins_transfer,
   output logic                              rsp_ends_transfer,
   output logic                              rsp_overflowed,
   output logic                              rsp_last
);

   logic                      active_ff, active_in;
   logic [dsf_pkg::POS_W-1:0] count_ff, count_in;
   dsf_pkg::frame_type        frame_ff, frame_in;

   // free when idle or on the final byte of the current run
   assign ready = !active_ff || (count_ff == dsf_pkg::POS_DISPLAY);

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      frame_in  = frame_ff;
      if (load) begin
         active_in = 1'b1;
         count_in  = dsf_pkg::POS_DATA_MODE;
         frame_in  = frame;
      end else if (active_ff) begin
         if (count_ff == dsf_pkg::POS_DISPLAY) begin
            active_in = 1'b0;
         end else begin
            count_in = count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= dsf_pkg::POS_DATA_MODE;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   always_comb begin
      rsp_valid           = active_ff;
      rsp_overflowed      = frame_ff.overflowed;
      rsp_last            = 1'b0;
      rsp_begins_transfer = 1'b0;
      rsp_ends_transfer   = 1'b0;
      unique case (count_ff)
         dsf_pkg::POS_DATA_MODE: begin
            rsp_frame_byte      = dsf_pkg::CMD_DATA_MODE;
            rsp_begins_transfer = 1'b1;
            rsp_ends_transfer   = 1'b1;
         end
         dsf_pkg::POS_ADDRESS: begin
            rsp_frame_byte      = dsf_pkg::CMD_ADDRESS;
            rsp_begins_transfer = 1'b1;
         end
         dsf_pkg::POS_THOUSANDS: rsp_frame_byte = frame_ff.seg[0];
         dsf_pkg::POS_HUNDREDS:  rsp_frame_byte = frame_ff.seg[1];
         dsf_pkg::POS_TENS:      rsp_frame_byte = frame_ff.seg[2];
         dsf_pkg::POS_UNITS: begin
            rsp_frame_byte    = frame_ff.seg[3];
            rsp_ends_transfer = 1'b1;
         end
         dsf_pkg::POS_DISPLAY: begin
            rsp_frame_byte      = 8'(dsf_pkg::CMD_DISPLAY + {4'b0, display_control});
            rsp_begins_transfer = 1'b1;
            rsp_ends_transfer   = 1'b1;
            rsp_last            = 1'b1;
         end
         default: rsp_frame_byte = 8'h00;
      endcase
   end

   // a run never walks past its last byte
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (count_ff <= dsf_pkg::POS_DISPLAY))
      else $error("byte position out of range");

   // loading a frame always restarts at the data-mode command
   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      load |=> (active_ff && count_ff == dsf_pkg::POS_DATA_MODE))
      else $error("run did not start at first byte");

   // a frame is only taken when the previous run is finishing or absent
   a_no_cut: assert property (@(posedge clock) disable iff (reset)
      load |-> ready)
      else $error("frame loaded over a run in progress");

   // without a new frame, the final byte ends the burst of strobes
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last && !load) |=> !rsp_valid)
      else $error("strobe continued after last byte");

endmodule

`default_nettype wire

### hw/rtl/decimal_seven_segment_frames_top.sv
// decimal_seven_segment_frames_top: request register, display control
// register and the conversion and byte sender; uses dsf_pkg, dsf_conv, dsf_emit
`default_nettype none

// Shows a 16-bit value on a four-digit seven-segment display controller.
// request: pulse start with req_value while busy is low; the request is
//   taken at that clock edge. busy goes high while one request waits in the
//   input register behind a run that is still being sent.
// response: each request gives a run of seven bytes on rsp_frame_byte, one
//   per cycle, each marked by a one-cycle rsp_valid strobe:
//   data-mode command, address command, four segment bytes (thousands first),
//   display-control command. rsp_begins_transfer / rsp_ends_transfer mark bus
//   start and stop conditions, rsp_last flags the seventh byte, and
//   rsp_overflowed is set on the whole run when the value was above 9999
//   (the digits then show 9999).
// order: an accepted request goes through the request register, then the
//   sender's registers, when idle; the bytes of one run follow back to back.
// back to back: runs share the single byte lane of the output; a waiting
//   request starts its run the cycle after the previous last byte.
// csr: csr_write_enable writes csr_write_data into display control (bit 3
//   enable, bits 2..0 brightness); write it only while idle. it is read when
//   the last byte of a run goes out.
// reset: synchronous, drops any pending request and run, display control
//   returns to enabled at full brightness. the receiver cannot stall; every
//   strobe must be taken in its cycle.

module decimal_seven_segment_frames_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [dsf_pkg::VALUE_W-1:0]  req_value,
   output logic                              rsp_valid,
   output logic [7:0]                        rsp_frame_byte,
   output logic                              rsp_begins_transfer,
   output logic                              rsp_ends_transfer,
   output logic                              rsp_overflowed,
   output logic                              rsp_last,
   input  wire logic                         csr_write_enable,
   input  wire logic [dsf_pkg::CTRL_W-1:0]   csr_write_data
);

   // request register
   logic                         req_valid_ff, req_valid_in;
   logic [dsf_pkg::VALUE_W-1:0]  req_value_ff, req_value_in;
   // display control register
   logic [dsf_pkg::CTRL_W-1:0]   ctrl_ff, ctrl_in;

   logic               accept;
   logic               emit_ready;
   logic               load;
   dsf_pkg::frame_type conv_frame;

   // the request register moves into the sender whenever it is free
   assign load   = req_valid_ff && emit_ready;
   assign busy   = req_valid_ff && !emit_ready;
   assign accept = start && !busy;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_value_in = req_value_ff;
      if (accept) begin
         req_valid_in = 1'b1;
         req_value_in = req_value;
      end else if (load) begin
         req_valid_in = 1'b0;
      end
      ctrl_in = csr_write_enable ? csr_write_data : ctrl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         ctrl_ff      <= dsf_pkg::CONTROL_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      req_value_ff <= req_value_in;
   end

   // clamp, decimal split and segment map between request and frame registers
   dsf_conv u_conv (
      .value (req_value_ff),
      .frame (conv_frame)
   );

   dsf_emit u_emit (
      .clock               (clock),
      .reset               (reset),
      .load                (load),
      .frame               (conv_frame),
      .display_control     (ctrl_ff),
      .ready               (emit_ready),
      .rsp_valid           (rsp_valid),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_begins_transfer (rsp_begins_transfer),
      .rsp_ends_transfer   (rsp_ends_transfer),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_last            (rsp_last)
   );

   // an accepted request is held until the sender takes it
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !emit_ready) |=> (req_valid_ff && $stable(req_value_ff)))
      else $error("pending request lost or changed");

   // a taken request starts a run on the next cycle
   a_load_strobe: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid && rsp_frame_byte == dsf_pkg::CMD_DATA_MODE))
      else $error("run did not follow request");

   // overflow flag never changes inside a run
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> (rsp_valid && $stable(rsp_overflowed)))
      else $error("overflow flag changed within run");

endmodule

`default_nettype wire

### tb/decimal_seven_segment_frames_top_tb.sv
`timescale 1ns / 100ps
// decimal_seven_segment_frames_top_tb: self-checking bench for the decimal
// seven-segment frame generator; predicts each seven-byte run and compares
// every strobed byte; needs dsf_pkg and decimal_seven_segment_frames_top

module decimal_seven_segment_frames_top_tb;

   // consecutive cycles with no request taken and no byte seen
   localparam int WATCHDOG_LIMIT = 1000;
   // quiet cycles after the last byte, before a csr write or the verdict
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_PER_PHASE = 50;

   // one byte of a run as the block should strobe it
   typedef struct {
      logic [7:0] frame_byte;
      logic       begins;
      logic       ends;
      logic       ovf;
      logic       is_last;
   } frame_entry_type;

   logic                         clock;
   logic                         reset;
   logic                         start = 1'b0;
   logic                         busy;
   logic [dsf_pkg::VALUE_W-1:0]  req_value = '0;
   logic                         rsp_valid;
   logic [7:0]                   rsp_frame_byte;
   logic                         rsp_begins_transfer;
   logic                         rsp_ends_transfer;
   logic                         rsp_overflowed;
   logic                         rsp_last;
   logic                         csr_write_enable;
   logic [dsf_pkg::CTRL_W-1:0]   csr_write_data;

   frame_entry_type              expected_frames[$];   // bytes still owed by the block
   logic [dsf_pkg::VALUE_W-1:0]  pending_values[$];    // requests not yet driven
   logic [dsf_pkg::CTRL_W-1:0]   display_control_model;
   bit                           req_taken;            // set at the edge that took a request
   bit                           steady_drive;         // no idle gaps while set
   int                           mismatch_count = 0;
   int                           idle_cycles;

   decimal_seven_segment_frames_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_frame_byte      (rsp_frame_byte),
      .rsp_begins_transfer (rsp_begins_transfer),
      .rsp_ends_transfer   (rsp_ends_transfer),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // segment a in bit 0 through segment g in bit 6
   function automatic logic [7:0] segments_for_digit(input int digit);
      case (digit)
         0:       return 8'h3F;
         1:       return 8'h06;
         2:       return 8'h5B;
         3:       return 8'h4F;
         4:       return 8'h66;
         5:       return 8'h6D;
         6:       return 8'h7D;
         7:       return 8'h07;
         8:       return 8'h7F;
         default: return 8'h6F;
      endcase
   endfunction

   // queue the seven bytes one request should produce
   function automatic void predict_frame_run(input logic [dsf_pkg::VALUE_W-1:0] value);
      int              shown;
      int              divisor;
      logic            ovf;
      frame_entry_type entry;
      shown = int'(value);
      ovf   = 1'b0;
      // anything past four digits saturates to all nines
      if (shown > 9999) begin
         shown = 9999;
         ovf   = 1'b1;
      end
      entry = '{dsf_pkg::CMD_DATA_MODE, 1'b1, 1'b1, ovf, 1'b0};
      expected_frames.push_back(entry);
      entry = '{dsf_pkg::CMD_ADDRESS, 1'b1, 1'b0, ovf, 1'b0};
      expected_frames.push_back(entry);
      // thousands first, the units byte closes the address transfer
      divisor = 1000;
      for (int i = 0; i < 4; i++) begin
         entry = '{segments_for_digit((shown / divisor) % 10), 1'b0, (i == 3), ovf, 1'b0};
         expected_frames.push_back(entry);
         divisor = divisor / 10;
      end
      entry = '{8'(dsf_pkg::CMD_DISPLAY + {4'b0000, display_control_model}),
                1'b1, 1'b1, ovf, 1'b1};
      expected_frames.push_back(entry);
   endfunction

   task automatic check_field(input string what, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // mostly showable values, a fair share past 9999 and around the digit edges
   function automatic logic [dsf_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55)
         return dsf_pkg::VALUE_W'($urandom_range(9999));
      else if (roll < 70)
         return dsf_pkg::VALUE_W'($urandom_range(65535, 10000));
      else if (roll < 85) begin
         case ($urandom_range(5))
            0:       return 16'd9999;
            1:       return 16'd10000;
            2:       return 16'd0;
            3:       return 16'hFFFF;
            4:       return dsf_pkg::VALUE_W'($urandom_range(9) * 1000 + 999);
            default: return dsf_pkg::VALUE_W'($urandom_range(9) * 1000);
         endcase
      end
      return dsf_pkg::VALUE_W'($urandom);
   endfunction

   // request driver: changes start and value on the falling edge only
   always @(negedge clock) begin : request_driver
      logic                        next_start;
      logic [dsf_pkg::VALUE_W-1:0] next_value;
      if (!reset) begin
         next_start = start;
         next_value = req_value;
         // hold a request until an edge takes it, then move on
         if (!start || req_taken) begin
            next_start = 1'b0;
            next_value = dsf_pkg::VALUE_W'($urandom);   // junk while start is low
            if (pending_values.size() != 0 &&
                (steady_drive || $urandom_range(99) >= 17)) begin
               next_start = 1'b1;
               next_value = pending_values.pop_front();
            end
         end
         start     <= next_start;
         req_value <= next_value;
      end
   end

   // monitor: takes requests and bytes at the rising edge, plus the watchdog
   always @(posedge clock) begin : frame_monitor
      frame_entry_type want;
      bit              progress;
      req_taken = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         progress = 1'b0;
         if (start && !busy) begin
            req_taken = 1'b1;
            progress  = 1'b1;
            predict_frame_run(req_value);
         end
         if (rsp_valid) begin
            progress = 1'b1;
            if (expected_frames.size() == 0) begin
               $display("%0t: byte %0h expected none actual strobe", $time,
                        rsp_frame_byte);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               check_field("frame_byte", want.frame_byte, rsp_frame_byte);
               check_field("begins_transfer", 8'(want.begins),
                           8'(rsp_begins_transfer));
               check_field("ends_transfer", 8'(want.ends), 8'(rsp_ends_transfer));
               check_field("overflowed", 8'(want.ovf), 8'(rsp_overflowed));
               check_field("last", 8'(want.is_last), 8'(rsp_last));
            end
         end
         if (progress) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no progress for %0d cycles", $time, idle_cycles);
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

   // block is idle once nothing is queued, driven or owed
   task automatic drain_and_settle();
      while (pending_values.size() != 0 || start || expected_frames.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_display_control(input logic [dsf_pkg::CTRL_W-1:0] setting);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= setting;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= dsf_pkg::CTRL_W'($urandom);
      display_control_model = setting;
   endtask

   task automatic queue_random_values(input int count);
      repeat (count) pending_values.push_back(pick_value());
   endtask

   initial begin : stimulus
      logic [dsf_pkg::VALUE_W-1:0] corner_values[$];
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      steady_drive     = 1'b0;
      display_control_model = dsf_pkg::CONTROL_RESET;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: digit boundaries, saturation edge, every digit, field extremes
      corner_values = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
                        16'd1000, 16'd1234, 16'd5678, 16'd9876, 16'd4090,
                        16'd9998, 16'd9999, 16'd10000, 16'd10001, 16'h8000,
                        16'hAAAA, 16'h5555, 16'hFFFF};
      foreach (corner_values[i]) pending_values.push_back(corner_values[i]);
      drain_and_settle();

      // display off, lowest brightness
      write_display_control(4'd0);
      queue_random_values(RANDOM_PER_PHASE);
      drain_and_settle();

      // enabled at lowest brightness, driven back to back
      steady_drive = 1'b1;
      write_display_control(4'd8);
      queue_random_values(RANDOM_PER_PHASE);
      drain_and_settle();
      steady_drive = 1'b0;

      // disabled at full brightness
      write_display_control(4'd7);
      queue_random_values(RANDOM_PER_PHASE);
      drain_and_settle();

      write_display_control(dsf_pkg::CTRL_W'($urandom_range(15)));
      queue_random_values(RANDOM_PER_PHASE);
      drain_and_settle();

      // back to the reset setting
      write_display_control(4'd15);
      queue_random_values(RANDOM_PER_PHASE);
      drain_and_settle();

      if (mismatch_count == 0 && expected_frames.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
